### src/gsa_pkg.sv
// gsa_pkg: types and constants shared by the generational slot allocator
// no dependencies; imported by generational_slot_allocator

package gsa_pkg;

	// table sizes, fixed by the widths of the slot index and body id fields
	localparam int SLOTS    = 1024;
	localparam int BODIES   = 4096;
	localparam int GEN_BITS = 32;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int BID_W  = $clog2(BODIES);
	localparam int CNT_W  = SLOT_W + 1;

	// operation codes
	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_CHECK   = 2'd2,
		CMD_LOOKUP  = 2'd3
	} cmd_e_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_e_t;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_READ1  = 4'b0010,
		S_READ2  = 4'b0100,
		S_UNLINK = 4'b1000
	} state_e_t;

	// one slot entry; next links the free list when the slot is free
	typedef struct packed {
		logic [GEN_BITS-1:0] gen;
		logic                free;
		logic                bvalid;
		logic [BID_W-1:0]    bid;
		logic [SLOT_W-1:0]   next;
	} slot_ent_t;

	// one reverse map entry, body id to slot
	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
	} link_ent_t;

endpackage

### src/generational_slot_allocator.sv
// generational_slot_allocator: slot table with generation counters and body reverse map
// depends on gsa_pkg (sizes, codes, memory entry types)
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------------
//   in      | in_valid, in_stall | cmd, slot_index, handle_generation, has_body,
//           |                    | body_id
//   out     | out_valid, out_stall | status, result_index, result_generation,
//           |                    | handle_ok
//
// add, check, failed commands and lookup misses end in S_READ1; release of a slot
// holding a body goes on to S_UNLINK and a lookup hit to S_READ2, set by the chained
// reads of the slot memory and the body link memory (one registered read port each).
// after reset a clearing pass writes every body link entry, in_stall high throughout.
// one item is in work at a time; a finished result waits in a holding register
// and the output register, so one more transfer is taken while out_stall is high.

module generational_slot_allocator (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               cmd,
	input  logic [9:0]               slot_index,
	input  logic [31:0]              handle_generation,
	input  logic                     has_body,
	input  logic [11:0]              body_id,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic [9:0]               result_index,
	output logic [31:0]              result_generation,
	output logic                     handle_ok
);

	import gsa_pkg::*;

	// memories and their read data
	slot_ent_t slot_mem [SLOTS];
	link_ent_t link_mem [BODIES];
	slot_ent_t slot_rd;
	link_ent_t link_rd;

	logic              slot_we;
	logic [SLOT_W-1:0] slot_wa;
	slot_ent_t         slot_wd;
	logic [SLOT_W-1:0] slot_ra;
	logic              link_we;
	logic [BID_W-1:0]  link_wa;
	link_ent_t         link_wd;
	logic [BID_W-1:0]  link_ra;

	// control state
	state_e_t          state_q, state_d;
	logic              clr_q;
	logic [BID_W-1:0]  clr_addr_q;
	logic [CNT_W-1:0]  used_q, used_d;
	logic [CNT_W-1:0]  free_cnt_q, free_cnt_d;
	logic [SLOT_W-1:0] head_q, head_d;
	logic              pend_q;
	logic              out_valid_q;

	// captured command
	cmd_e_t              cmd_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [31:0]         hgen_q;
	logic                has_q;
	logic [BID_W-1:0]    bid_q;
	logic [BID_W-1:0]    old_bid_q, old_bid_d;

	// pending result
	status_e_t         res_status_q, res_status_d;
	logic [SLOT_W-1:0] res_index_q, res_index_d;
	logic [31:0]       res_gen_q, res_gen_d;
	logic              res_ok_q, res_ok_d;
	logic              fin;

	// output register
	status_e_t         out_status_q;
	logic [SLOT_W-1:0] out_index_q;
	logic [31:0]       out_gen_q;
	logic              out_ok_q;

	logic                in_xfer;
	logic                out_free;
	logic                out_load;
	logic                idx_out_rng;
	logic [GEN_BITS-1:0] gen_inc;
	logic [GEN_BITS-1:0] gen_next;

	// handshakes
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = pend_q && out_free;
	assign in_stall = !((state_q == S_IDLE) && !clr_q && (!pend_q || out_free));
	assign in_xfer  = in_valid && !in_stall;

	// generation bump, skipping zero on wrap
	assign gen_inc  = slot_rd.gen + GEN_BITS'(1);
	assign gen_next = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

	assign idx_out_rng = ({1'b0, idx_q} >= used_q);

	// slot memory
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		slot_rd <= slot_mem[slot_ra];
	end

	// body link memory
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		link_rd <= link_mem[link_ra];
	end

	// sequencer and read-modify-write of both memories
	always_comb begin
		state_d      = state_q;
		used_d       = used_q;
		free_cnt_d   = free_cnt_q;
		head_d       = head_q;
		old_bid_d    = old_bid_q;
		res_status_d = res_status_q;
		res_index_d  = res_index_q;
		res_gen_d    = res_gen_q;
		res_ok_d     = res_ok_q;
		fin          = 1'b0;
		slot_we      = 1'b0;
		slot_wa      = idx_q;
		slot_wd      = slot_rd;
		slot_ra      = (cmd_e_t'(cmd) == CMD_ADD) ? head_q : slot_index;
		link_we      = 1'b0;
		link_wa      = bid_q;
		link_wd      = '0;
		link_ra      = body_id;

		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_d = S_READ1;
				end
			end
			S_READ1: begin
				// chained reads for release and lookup
				link_ra      = slot_rd.bid;
				slot_ra      = link_rd.slot;
				state_d      = S_IDLE;
				fin          = 1'b1;
				res_status_d = ST_OK;
				res_index_d  = idx_q;
				res_gen_d    = '0;
				res_ok_d     = 1'b0;
				unique case (cmd_q)
					CMD_ADD: begin
						if (free_cnt_q != '0) begin
							// reuse the most recently freed slot, which holds no body
							slot_we        = 1'b1;
							slot_wa        = head_q;
							slot_wd.gen    = gen_next;
							slot_wd.free   = 1'b0;
							slot_wd.bvalid = has_q;
							slot_wd.bid    = has_q ? bid_q : '0;
							slot_wd.next   = slot_rd.next;
							link_we        = has_q;
							link_wd.valid  = 1'b1;
							link_wd.slot   = head_q;
							head_d         = slot_rd.next;
							free_cnt_d     = free_cnt_q - CNT_W'(1);
							res_index_d    = head_q;
							res_gen_d      = 32'(gen_next);
						end else if (used_q < CNT_W'(SLOTS)) begin
							// fresh slot at generation one
							slot_we        = 1'b1;
							slot_wa        = used_q[SLOT_W-1:0];
							slot_wd.gen    = GEN_BITS'(1);
							slot_wd.free   = 1'b0;
							slot_wd.bvalid = has_q;
							slot_wd.bid    = has_q ? bid_q : '0;
							slot_wd.next   = '0;
							link_we        = has_q;
							link_wd.valid  = 1'b1;
							link_wd.slot   = used_q[SLOT_W-1:0];
							used_d         = used_q + CNT_W'(1);
							res_index_d    = used_q[SLOT_W-1:0];
							res_gen_d      = 32'd1;
						end else begin
							res_status_d = ST_FULL;
							res_index_d  = '0;
						end
					end
					CMD_RELEASE: begin
						if (idx_out_rng) begin
							res_status_d = ST_BAD_INDEX;
						end else if (slot_rd.free) begin
							res_status_d = ST_BAD_INDEX;
							res_gen_d    = 32'(slot_rd.gen);
						end else begin
							// bump, drop the body and push on the free list
							slot_we        = 1'b1;
							slot_wd.gen    = gen_next;
							slot_wd.free   = 1'b1;
							slot_wd.bvalid = 1'b0;
							slot_wd.bid    = '0;
							slot_wd.next   = head_q;
							head_d         = idx_q;
							free_cnt_d     = free_cnt_q + CNT_W'(1);
							res_gen_d      = 32'(gen_next);
							if (slot_rd.bvalid) begin
								old_bid_d = slot_rd.bid;
								fin       = 1'b0;
								state_d   = S_UNLINK;
							end
						end
					end
					CMD_CHECK: begin
						if (idx_out_rng) begin
							res_status_d = ST_BAD_INDEX;
						end else begin
							res_gen_d = 32'(slot_rd.gen);
							res_ok_d  = (hgen_q != '0) && (32'(slot_rd.gen) == hgen_q);
						end
					end
					CMD_LOOKUP: begin
						if (has_q && link_rd.valid) begin
							res_index_d = link_rd.slot;
							fin         = 1'b0;
							state_d     = S_READ2;
						end else begin
							res_status_d = ST_NOT_FOUND;
							res_index_d  = '0;
						end
					end
					default: begin
						res_status_d = ST_OK;
					end
				endcase
			end
			S_READ2: begin
				// generation of the linked slot
				res_gen_d = 32'(slot_rd.gen);
				fin       = 1'b1;
				state_d   = S_IDLE;
			end
			S_UNLINK: begin
				// unmap the old body only while its link still names this slot
				if (link_rd.valid && (link_rd.slot == idx_q)) begin
					link_we = 1'b1;
					link_wa = old_bid_q;
					link_wd = '0;
				end
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// clearing pass after reset
		if (clr_q) begin
			link_we = 1'b1;
			link_wa = clr_addr_q;
			link_wd = '0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			used_q      <= '0;
			free_cnt_q  <= '0;
			head_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			used_q     <= used_d;
			free_cnt_q <= free_cnt_d;
			head_q     <= head_d;
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + BID_W'(1);
				if (clr_addr_q == BID_W'(BODIES - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (fin) begin
				pend_q <= 1'b1;
			end else if (out_load) begin
				pend_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q  <= cmd_e_t'(cmd);
			idx_q  <= slot_index;
			hgen_q <= handle_generation;
			has_q  <= has_body && ({1'b0, body_id} < (BID_W + 1)'(BODIES));
			bid_q  <= body_id;
		end
		old_bid_q    <= old_bid_d;
		res_status_q <= res_status_d;
		res_index_q  <= res_index_d;
		res_gen_q    <= res_gen_d;
		res_ok_q     <= res_ok_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_gen_q    <= res_gen_q;
			out_ok_q     <= res_ok_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = out_status_q;
	assign result_index      = out_index_q;
	assign result_generation = out_gen_q;
	assign handle_ok         = out_ok_q;

	// free slots are always a subset of the slots handed out
	a_free_within_used: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= used_q)
		else $error("free slot count exceeds slots in use");

	// a command is worked on only after a transfer was taken
	a_read1_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ1) |-> $past(in_xfer))
		else $error("command stage entered without an input transfer");

	// no input transfer while the body links are being cleared
	a_no_xfer_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> in_stall)
		else $error("input taken during clearing pass");

	// a held result is not dropped while the output is blocked
	a_pend_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && out_valid_q && out_stall) |=> pend_q)
		else $error("pending result lost while output stalled");

	// a finished item never overwrites a result still pending
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !pend_q)
		else $error("result finished while previous one still pending");

endmodule
